@@ src/bas_pkg.sv @@
package bas_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // result of one compare-exchange step
  typedef struct packed {
    data_t lo;
    data_t hi;
  } minmax_t;

endpackage

@@ src/bas_mem.sv @@
module bas_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bas_pkg::data_t   wdata,
  input  logic [AW-1:0]    raddr,
  output bas_pkg::data_t   rdata
);

  bas_pkg::data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/bas_cmp.sv @@
module bas_cmp (
  input  bas_pkg::data_t  a,
  input  bas_pkg::data_t  b,
  output bas_pkg::minmax_t res
);

  always_comb begin
    if (b < a) begin
      res.lo = b;
      res.hi = a;
    end else begin
      res.lo = a;
      res.hi = b;
    end
  end

endmodule

@@ src/batch_ascending_sorter.sv @@
// channel | dir | tdata                  | tlast           | tuser
// s_*     | in  | [31:0] data_value      | last_in         | -
// m_*     | out | [31:0] sorted_value    | last_out        | -
//
// collect: one item per cycle into the element memory until tlast; items past DEPTH are dropped
// sort: bubble passes over the memory, one read and one write a cycle;
//   each pass covers m entries, m runs from n down to 2
// emit: each result is read from memory, then loaded into the output register
// s_tready is low from the closing item until the last result is taken
// rst is synchronous; the element memory is not cleared
module batch_ascending_sorter #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    COLLECT, PASS, FLUSH, EMIT_RD, EMIT_LD, EMIT_WAIT
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       total;
  logic [CNT_W-1:0]       lim;
  logic [CNT_W-1:0]       n_close;
  logic [CNT_W-1:0]       lim_next;
  logic [AW-1:0]          rd_idx;
  logic                   rd_done;
  logic                   dv;
  logic [AW-1:0]          di;
  logic [AW-1:0]          k;
  logic [AW-1:0]          lim_top;
  bas_pkg::data_t         carry;
  bas_pkg::minmax_t       mm;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  bas_pkg::data_t         mem_wdata;
  logic [AW-1:0]          mem_raddr;
  bas_pkg::data_t         mem_rdata;

  logic in_acc;
  logic has_room;

  assign s_tready = (state == COLLECT);
  assign in_acc   = s_tvalid && s_tready;
  assign has_room = (count < CNT_W'(DEPTH));
  assign n_close  = has_room ? count + CNT_W'(1) : count;
  assign lim_next = lim - CNT_W'(1);
  assign lim_top  = AW'(lim - CNT_W'(1));

  bas_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bas_cmp u_cmp (
    .a   (carry),
    .b   (mem_rdata),
    .res (mm)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = di - AW'(1);
    mem_wdata = mm.lo;
    mem_raddr = rd_idx;
    case (state)
      COLLECT: begin
        mem_we    = in_acc && has_room;
        mem_waddr = AW'(count);
        mem_wdata = bas_pkg::data_t'(s_tdata);
      end
      PASS: begin
        mem_we = dv && (di != '0);
      end
      FLUSH: begin
        mem_we    = 1'b1;
        mem_waddr = lim_top;
        mem_wdata = carry;
      end
      EMIT_RD: begin
        mem_raddr = k;
      end
      EMIT_WAIT: begin
        mem_raddr = k + AW'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= COLLECT;
      count    <= '0;
      m_tvalid <= 1'b0;
      dv       <= 1'b0;
      rd_done  <= 1'b0;
    end else begin
      case (state)
        COLLECT: begin
          if (in_acc) begin
            if (s_tlast) begin
              count   <= '0;
              total   <= n_close;
              lim     <= n_close;
              rd_idx  <= '0;
              rd_done <= 1'b0;
              dv      <= 1'b0;
              k       <= '0;
              state   <= (n_close == CNT_W'(1)) ? EMIT_RD : PASS;
            end else if (has_room) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        PASS: begin
          // issue reads 0..m-1 back to back
          if (!rd_done) begin
            dv <= 1'b1;
            di <= rd_idx;
            if (rd_idx == lim_top) begin
              rd_done <= 1'b1;
            end else begin
              rd_idx <= rd_idx + AW'(1);
            end
          end else begin
            dv <= 1'b0;
          end
          // data arrives in the following cycle: carry the running maximum
          if (dv) begin
            if (di == '0) begin
              carry <= mem_rdata;
            end else begin
              carry <= mm.hi;
            end
            if (di == lim_top) begin
              state <= FLUSH;
            end
          end
        end
        FLUSH: begin
          dv      <= 1'b0;
          lim     <= lim_next;
          rd_idx  <= '0;
          rd_done <= 1'b0;
          state   <= (lim_next == CNT_W'(1)) ? EMIT_RD : PASS;
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          m_tdata  <= mem_rdata;
          m_tlast  <= (k == AW'(total - CNT_W'(1)));
          m_tvalid <= 1'b1;
          state    <= EMIT_WAIT;
        end
        EMIT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= COLLECT;
            end else begin
              k     <= k + AW'(1);
              state <= EMIT_LD;
            end
          end
        end
        default: begin
          state <= COLLECT;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count beyond depth");

  a_pass_lim: assert property (@(posedge clk) disable iff (rst)
    (state == PASS || state == FLUSH) |-> (lim >= CNT_W'(2) && lim <= total))
    else $error("sort pass limit out of range");

  a_back_to_collect: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("block did not return to collecting after final result");

endmodule

@@ tb/sv/sorter_checker.sv @@
`timescale 1ns / 1ps

module sorter_checker #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_value
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] sorted_value
  input  logic        m_tlast,
  output int          mismatches,
  output int          due_count,
  output int          batch_count,
  output int          result_count,
  output int          overflow_count
);

  typedef struct {
    bas_pkg::data_t value;
    logic           last_flag;
  } sorted_item_t;

  bas_pkg::data_t open_batch[$];
  sorted_item_t   sorted_due[$];
  sorted_item_t   oldest;
  bit             batch_overflowed;

  // ascending insertion sort of the open batch, queued as expected results
  function automatic void queue_sorted_batch();
    bas_pkg::data_t vals[$];
    bas_pkg::data_t key;
    int             j;
    sorted_item_t   entry;
    vals = open_batch;
    for (int i = 1; i < vals.size(); i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    for (int k = 0; k < vals.size(); k++) begin
      entry.value = vals[k];
      entry.last_flag = (k == vals.size() - 1);
      sorted_due.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      open_batch.delete();
      sorted_due.delete();
      batch_overflowed = 1'b0;
      due_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (open_batch.size() < DEPTH) begin
          open_batch.push_back(bas_pkg::data_t'(s_tdata));
        end else begin
          batch_overflowed = 1'b1;
        end
        if (s_tlast) begin
          queue_sorted_batch();
          batch_count++;
          if (batch_overflowed) begin
            overflow_count++;
          end
          open_batch.delete();
          batch_overflowed = 1'b0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (sorted_due.size() == 0) begin
          $error("sorted_value %0d last_out %b arrived with nothing due",
                 $signed(m_tdata), m_tlast);
          mismatches++;
        end else begin
          oldest = sorted_due.pop_front();
          if (m_tdata !== oldest.value) begin
            $error("sorted_value: expected %0d, got %0d", oldest.value, $signed(m_tdata));
            mismatches++;
          end
          if (m_tlast !== oldest.last_flag) begin
            $error("last_out: expected %b, got %b", oldest.last_flag, m_tlast);
            mismatches++;
          end
          result_count++;
        end
      end
      due_count = sorted_due.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int             DEPTH        = 64;
  localparam int             RANDOM_ITEMS = 140;
  localparam int             HOLD_CYCLES  = 300;
  localparam bas_pkg::data_t DATA_MIN     = bas_pkg::data_t'(32'h8000_0000);
  localparam bas_pkg::data_t DATA_MAX     = bas_pkg::data_t'(32'h7fff_ffff);

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;    // [31:0] data_value
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] sorted_value
  logic        m_tlast;

  int mismatches;
  int due_count;
  int batch_count;
  int result_count;
  int overflow_count;

  bas_pkg::data_t batch_vals[$];
  int             items_sent;
  bit             hold_req;
  bit             hold_done;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  batch_ascending_sorter #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  sorter_checker #(.DEPTH(DEPTH)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatches     (mismatches),
    .due_count      (due_count),
    .batch_count    (batch_count),
    .result_count   (result_count),
    .overflow_count (overflow_count)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // small values give duplicates, extremes hit the sign boundary
  function automatic bas_pkg::data_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return bas_pkg::data_t'(int'($urandom_range(0, 8)) - 4);
    if (r < 35) return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
    return bas_pkg::data_t'($urandom);
  endfunction

  task automatic offer_batch();
    int gap;
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < batch_vals.size(); k++) begin
      gap = burst ? 0 : pick_gap();
      repeat (gap) begin
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        s_tlast  <= 1'($urandom_range(0, 1));
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= batch_vals[k];
      s_tlast  <= (k == batch_vals.size() - 1);
      do @(negedge clk); while (!s_tready);
      @(posedge clk);
      items_sent++;
    end
  endtask

  // receiver: random stalls, steady stretches, one long hold-off
  initial begin
    int  run_left;
    int  stall_left;
    int  r;
    bit  steady;
    run_left = 0;
    stall_left = 0;
    steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (run_left == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      if (steady) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) stall_left = $urandom_range(8, 30);
        m_tready <= (r >= 30);
      end
    end
  end

  initial begin
    int random_sent;
    int batch_idx;
    int size;
    random_sent = 0;
    batch_idx = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-element batches at both extremes
    batch_vals = '{DATA_MIN};
    offer_batch();
    batch_vals = '{DATA_MAX};
    offer_batch();
    // repeated extremes mixed with values around zero
    batch_vals = '{DATA_MAX, DATA_MIN, 0, -32'sd1, 32'sd1, DATA_MIN, DATA_MAX};
    offer_batch();
    // strictly descending, then already ascending with equal values
    batch_vals = '{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1};
    offer_batch();
    batch_vals = '{-32'sd3, -32'sd3, 32'sd0, 32'sd7, 32'sd7};
    offer_batch();
    batch_vals = '{32'sd2, -32'sd2};
    offer_batch();

    // long receiver hold-off while items keep coming
    hold_req = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      if (batch_idx == 2) begin
        size = DEPTH + 3;             // past capacity, extras dropped
      end else if (batch_idx == 3) begin
        size = DEPTH;                 // exactly full
      end else if ($urandom_range(0, 7) == 0) begin
        size = $urandom_range(13, 30);
      end else begin
        size = $urandom_range(1, 12);
      end
      batch_vals.delete();
      repeat (size) batch_vals.push_back(pick_value());
      offer_batch();
      random_sent += (size > DEPTH) ? DEPTH : size;
      batch_idx++;
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (due_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d items in %0d batches, %0d of them over capacity", items_sent,
             batch_count, overflow_count);
    $display("checked %0d sorted results", result_count);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
